FILE: hdl/vpa_pkg.sv
// shared types and codes of the versioned persistent array
package vpa_pkg;

   localparam int VALUE_W = 32;

   typedef logic [1:0]         action_type;
   typedef logic [9:0]         version_type;
   typedef logic [10:0]        position_type;
   typedef logic [10:0]        len_cfg_type;
   typedef logic signed [31:0] value_type;
   typedef logic [2:0]         status_type;

   // item actions
   localparam action_type ACT_LOAD   = 2'd0;
   localparam action_type ACT_MODIFY = 2'd1;
   localparam action_type ACT_QUERY  = 2'd2;

   // result status
   localparam status_type STATUS_OK      = 3'd0;
   localparam status_type STATUS_BAD_POS = 3'd1;
   localparam status_type STATUS_BAD_VER = 3'd2;
   localparam status_type STATUS_FULL    = 3'd3;
   localparam status_type STATUS_LATE    = 3'd4;

endpackage

FILE: hdl/versioned_persistent_array.sv
// top level of the versioned persistent array: control, walk sequencer and stores
module versioned_persistent_array #(
   parameter int MAX_LEN      = 1024,
   parameter int MAX_VERSIONS = 1024,
   parameter int NODE_POOL    = 16384
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vpa_pkg::action_type  req_action,
   input  vpa_pkg::version_type req_base_version,
   input  vpa_pkg::position_type req_position,
   input  vpa_pkg::value_type   req_element_value,
   output logic                 rsp_valid,
   output vpa_pkg::value_type   rsp_read_value,
   output vpa_pkg::version_type rsp_created_version,
   output vpa_pkg::status_type  rsp_status,
   input  logic                 csr_we,
   input  vpa_pkg::len_cfg_type csr_wdata
);
   // The array lives as a path-copied binary tree in one node ram (left link,
   // right link, value per node) and a version table ram holding each
   // version's root. An item is taken when start is high and busy is low.
   // Load, modify and query items walk from the root to the leaf, one tree
   // level per cycle: the node read returns in the cycle after its address and
   // the copy of that node is written in the same cycle the next read goes
   // out. A walked item holds busy while it walks its path (path length is
   // ceil(log2(array_len)) + 1 nodes or one less) and its result strobes in
   // the first cycle with busy low. Items rejected on their checks, and the
   // unused action which gives no result, do not raise busy. After reset, and
   // after every array_len write while loading is open, a build pass writes
   // the base tree, one node a cycle, with busy high. Results are strobed on
   // rsp_valid for one cycle and cannot be held off.
   import vpa_pkg::*;

   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int NA_W      = $clog2(NODE_POOL);
   localparam int FP_W      = $clog2(NODE_POOL + 1);
   localparam int FR_W      = FP_W + 1;
   localparam int VER_W     = $clog2(MAX_VERSIONS);
   localparam int CNT_W     = $clog2(MAX_VERSIONS + 1);
   localparam int NODE_W    = 2 * NA_W + VALUE_W;
   localparam int LEN_RESET = (MAX_LEN > 1024) ? 1024 : MAX_LEN;

   // sequencer codes
   localparam logic [1:0] FSM_IDLE = 2'd0;
   localparam logic [1:0] FSM_ROOT = 2'd1;
   localparam logic [1:0] FSM_WALK = 2'd2;

   function automatic logic [NA_W-1:0] pool_ok(input logic [NA_W-1:0] a);
      pool_ok = (32'(a) < 32'(NODE_POOL)) ? a : '0;
   endfunction

   // nodes taken by the base tree, capped at the pool
   function automatic logic [FP_W-1:0] base_nodes(input logic [LEN_W-1:0] l);
      logic [31:0] s;
      s = 32'd2 * 32'(l) - 32'd1;
      base_nodes = (s < 32'(NODE_POOL)) ? FP_W'(s) : FP_W'(NODE_POOL);
   endfunction

   // control and context registers
   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             open_ff, open_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [FP_W-1:0]  fp_ff, fp_in;
   logic             boot_ff;
   action_type       op_ff, op_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   value_type        value_ff, value_in;
   logic             zero_root_ff, zero_root_in;
   logic [NA_W-1:0]  root_ff, root_in;
   logic [NA_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic             leaf_ff, leaf_in, left_ff, left_in;
   logic [FR_W-1:0]  fresh_ff, fresh_in;

   // result registers
   logic             rsp_valid_ff, rsp_valid_in;
   value_type        rsp_value_ff, rsp_value_in;
   version_type      rsp_version_ff, rsp_version_in;
   status_type       rsp_status_ff, rsp_status_in;

   // store ports
   logic              node_we, walk_we, bld_we;
   logic [NA_W-1:0]   node_waddr, walk_waddr, bld_waddr, node_raddr;
   logic [NODE_W-1:0] node_wdata, walk_wdata, bld_wdata, node_rdata;
   logic              root_we;
   logic [VER_W-1:0]  root_waddr, root_raddr;
   logic [NA_W-1:0]   root_wdata, root_rdata;

   logic              bld_start, bld_busy;
   logic [LEN_W-1:0]  bld_len;

   // decode and checks
   logic              take, cfg_take;
   logic [31:0]       csr_wide;
   logic [LEN_W-1:0]  csr_len;
   logic              pos_bad, ver_bad, table_full;

   // one tree level step
   logic [LEN_W-1:0]  cur_lo, cur_hi, mid, child_lo, child_hi;
   logic [LEN_W:0]    mid_sum;
   logic              step_leaf, step_left;
   logic [NA_W-1:0]   rd_left, rd_right, root_sel, child;
   logic [31:0]       rd_value;
   logic [NA_W-1:0]   fresh_link;
   logic              fresh_ok;
   logic [NODE_W-1:0] copy_word;

   assign busy     = boot_ff || bld_busy || (state_ff != FSM_IDLE);
   assign take     = start && !busy;
   assign cfg_take = csr_we && open_ff;

   // array_len write is clamped to 1..MAX_LEN
   assign csr_wide = 32'(csr_wdata);
   always_comb begin
      if (csr_wide == 32'd0) begin
         csr_len = LEN_W'(1);
      end else if (csr_wide > 32'(MAX_LEN)) begin
         csr_len = LEN_W'(MAX_LEN);
      end else begin
         csr_len = LEN_W'(csr_wide);
      end
   end

   assign pos_bad    = (req_position == '0) || (32'(req_position) > 32'(len_ff));
   assign ver_bad    = (32'(req_base_version) >= 32'(count_ff)) ||
                       (32'(req_base_version) >= 32'(MAX_VERSIONS));
   assign table_full = (32'(count_ff) >= 32'(MAX_VERSIONS));

   // node fields as they come out of the ram
   assign rd_value = node_rdata[VALUE_W-1:0];
   assign rd_right = node_rdata[NA_W+VALUE_W-1:VALUE_W];
   assign rd_left  = node_rdata[2*NA_W+VALUE_W-1:NA_W+VALUE_W];

   // version 0 always roots at node 0, the first node the builder makes
   assign root_sel = zero_root_ff ? '0 : pool_ok(root_rdata);
   assign child    = pool_ok(left_ff ? rd_left : rd_right);

   // range of the node about to be read, its split point and the way down
   assign cur_lo    = (state_ff == FSM_ROOT) ? LEN_W'(1) : lo_ff;
   assign cur_hi    = (state_ff == FSM_ROOT) ? len_ff : hi_ff;
   assign mid_sum   = {1'b0, cur_lo} + {1'b0, cur_hi};
   assign mid       = mid_sum[LEN_W:1];
   assign step_leaf = (cur_lo == cur_hi);
   assign step_left = (pos_ff <= mid);
   assign child_lo  = step_left ? cur_lo : mid + LEN_W'(1);
   assign child_hi  = step_left ? mid : cur_hi;

   // path copy: fresh nodes are taken in order, so the copied child is the next one;
   // fresh nodes past the pool are not written and the item fails its capacity check
   assign fresh_ok   = (32'(fresh_ff) < 32'(NODE_POOL));
   assign fresh_link = NA_W'(fresh_ff + FR_W'(1));
   always_comb begin
      if (leaf_ff) begin
         copy_word = {rd_left, rd_right, 32'(value_ff)};
      end else if (left_ff) begin
         copy_word = {fresh_link, rd_right, rd_value};
      end else begin
         copy_word = {rd_left, fresh_link, rd_value};
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      open_in      = open_ff;
      count_in     = count_ff;
      fp_in        = fp_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      zero_root_in = zero_root_ff;
      root_in      = root_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      leaf_in      = leaf_ff;
      left_in      = left_ff;
      fresh_in     = fresh_ff;

      rsp_valid_in   = 1'b0;
      rsp_value_in   = '0;
      rsp_version_in = '0;
      rsp_status_in  = STATUS_OK;

      node_raddr = addr_ff;
      walk_we    = 1'b0;
      walk_waddr = addr_ff;
      walk_wdata = node_rdata;
      root_raddr = VER_W'(req_base_version);
      root_we    = 1'b0;
      root_waddr = VER_W'(count_ff);
      root_wdata = root_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (take) begin
               op_in        = req_action;
               pos_in       = LEN_W'(req_position);
               value_in     = req_element_value;
               zero_root_in = (req_action == ACT_LOAD) || (req_base_version == '0);
               case (req_action)
                  ACT_LOAD: begin
                     if (!open_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_LATE;
                     end else if (pos_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_POS;
                     end else begin
                        state_in = FSM_ROOT;
                     end
                  end
                  ACT_MODIFY, ACT_QUERY: begin
                     // any modify or query closes loading, even a rejected one
                     open_in = 1'b0;
                     if (pos_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_POS;
                     end else if (ver_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_VER;
                     end else if (table_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        state_in = FSM_ROOT;
                     end
                  end
                  default: begin
                     // unused action: no result, no change
                  end
               endcase
            end
         end
         FSM_ROOT: begin
            // version root is in; send the root read out
            root_in    = root_sel;
            node_raddr = root_sel;
            addr_in    = root_sel;
            leaf_in    = step_leaf;
            left_in    = step_left;
            lo_in      = child_lo;
            hi_in      = child_hi;
            fresh_in   = FR_W'(fp_ff);
            state_in   = FSM_WALK;
         end
         FSM_WALK: begin
            if (op_ff == ACT_MODIFY) begin
               walk_we    = fresh_ok;
               walk_waddr = NA_W'(fresh_ff);
               walk_wdata = copy_word;
            end
            if (!leaf_ff) begin
               node_raddr = child;
               addr_in    = child;
               leaf_in    = step_leaf;
               left_in    = step_left;
               lo_in      = child_lo;
               hi_in      = child_hi;
               fresh_in   = fresh_ff + FR_W'(1);
            end else begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               case (op_ff)
                  ACT_LOAD: begin
                     // loads set the base leaf in place
                     walk_we    = 1'b1;
                     walk_waddr = addr_ff;
                     walk_wdata = {rd_left, rd_right, 32'(value_ff)};
                  end
                  ACT_QUERY: begin
                     rsp_value_in   = value_type'(rd_value);
                     rsp_version_in = version_type'(count_ff);
                     root_we        = 1'b1;
                     root_wdata     = root_ff;
                     count_in       = count_ff + CNT_W'(1);
                  end
                  default: begin
                     // modify commits only if the whole copied path fit in the pool
                     if (!fresh_ok) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_version_in = version_type'(count_ff);
                        root_we        = 1'b1;
                        root_wdata     = NA_W'(fp_ff);
                        fp_in          = FP_W'(fresh_ff + FR_W'(1));
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      // base tree rebuild after reset or on a length change while loading
      bld_start = boot_ff || cfg_take;
      bld_len   = cfg_take ? csr_len : len_ff;
      if (cfg_take) begin
         len_in = csr_len;
      end
      if (bld_start) begin
         fp_in    = base_nodes(bld_len);
         count_in = CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         len_ff       <= LEN_W'(LEN_RESET);
         open_ff      <= 1'b1;
         count_ff     <= CNT_W'(1);
         fp_ff        <= base_nodes(LEN_W'(LEN_RESET));
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         open_ff      <= open_in;
         count_ff     <= count_in;
         fp_ff        <= fp_in;
         boot_ff      <= 1'b0;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      value_ff       <= value_in;
      zero_root_ff   <= zero_root_in;
      root_ff        <= root_in;
      addr_ff        <= addr_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      leaf_ff        <= leaf_in;
      left_ff        <= left_in;
      fresh_ff       <= fresh_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_version_ff <= rsp_version_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_value      = rsp_value_ff;
   assign rsp_created_version = rsp_version_ff;
   assign rsp_status          = rsp_status_ff;

   // if builder and walk write in the same cycle, the builder write wins
   assign node_we    = bld_we || walk_we;
   assign node_waddr = bld_we ? bld_waddr : walk_waddr;
   assign node_wdata = bld_we ? bld_wdata : walk_wdata;

   vpa_builder #(
      .MAX_LEN   (MAX_LEN),
      .NODE_POOL (NODE_POOL)
   ) u_builder (
      .clock      (clock),
      .reset      (reset),
      .start      (bld_start),
      .len        (bld_len),
      .busy       (bld_busy),
      .node_we    (bld_we),
      .node_waddr (bld_waddr),
      .node_wdata (bld_wdata)
   );

   vpa_ram #(
      .DEPTH  (NODE_POOL),
      .DATA_W (NODE_W)
   ) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_waddr),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   vpa_ram #(
      .DEPTH  (MAX_VERSIONS),
      .DATA_W (NA_W)
   ) u_root_ram (
      .clock (clock),
      .we    (root_we),
      .waddr (root_waddr),
      .wdata (root_wdata),
      .raddr (root_raddr),
      .rdata (root_rdata)
   );

endmodule

FILE: hdl/vpa_ram.sv
// simple dual-port synchronous ram, one write port, one registered read port
module vpa_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 14
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/vpa_builder.sv
// base tree builder: writes the balanced tree in preorder, one node per cycle
module vpa_builder #(
   parameter int MAX_LEN   = 1024,
   parameter int NODE_POOL = 16384
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [$clog2(MAX_LEN + 1)-1:0]                len,
   output logic                                          busy,
   output logic                                          node_we,
   output logic [$clog2(NODE_POOL)-1:0]                  node_waddr,
   output logic [2*$clog2(NODE_POOL)+vpa_pkg::VALUE_W-1:0] node_wdata
);
   import vpa_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int NA_W  = $clog2(NODE_POOL);
   localparam int STK_D = $clog2(MAX_LEN) + 2;
   localparam int SP_W  = $clog2(STK_D + 1);
   localparam int TI_W  = $clog2(STK_D);
   localparam int BN_W  = $clog2(2 * MAX_LEN);

   logic [LEN_W-1:0] stk_lo_ff [STK_D];
   logic [LEN_W-1:0] stk_hi_ff [STK_D];
   logic [LEN_W-1:0] stk_lo_in [STK_D];
   logic [LEN_W-1:0] stk_hi_in [STK_D];
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [BN_W-1:0]  n_ff, n_in;

   logic [TI_W-1:0]  top_idx;
   logic [LEN_W-1:0] top_lo, top_hi, mid;
   logic [LEN_W:0]   mid_sum;
   logic             leaf;
   logic [31:0]      left_link, right_link;

   function automatic logic [NA_W-1:0] link(input logic [31:0] a);
      link = (a < 32'(NODE_POOL)) ? NA_W'(a) : '0;
   endfunction

   assign top_idx = TI_W'(sp_ff - SP_W'(1));
   assign top_lo  = stk_lo_ff[top_idx];
   assign top_hi  = stk_hi_ff[top_idx];
   assign mid_sum = {1'b0, top_lo} + {1'b0, top_hi};
   assign mid     = mid_sum[LEN_W:1];
   assign leaf    = (top_lo == top_hi);

   // preorder: left child follows at once, right child after the whole left subtree
   assign left_link  = 32'(n_ff) + 32'd1;
   assign right_link = 32'(n_ff) + 32'd2 * (32'(mid) - 32'(top_lo) + 32'd1);

   assign busy       = (sp_ff != '0);
   assign node_we    = busy && (32'(n_ff) < 32'(NODE_POOL));
   assign node_waddr = NA_W'(n_ff);
   assign node_wdata = leaf ? '0 : {link(left_link), link(right_link), VALUE_W'(0)};

   always_comb begin
      stk_lo_in = stk_lo_ff;
      stk_hi_in = stk_hi_ff;
      sp_in     = sp_ff;
      n_in      = n_ff;
      if (start) begin
         stk_lo_in[0] = LEN_W'(1);
         stk_hi_in[0] = len;
         sp_in        = SP_W'(1);
         n_in         = '0;
      end else if (busy) begin
         n_in = n_ff + BN_W'(1);
         if (leaf) begin
            sp_in = sp_ff - SP_W'(1);
         end else begin
            stk_lo_in[top_idx]     = mid + LEN_W'(1);
            stk_hi_in[top_idx]     = top_hi;
            stk_lo_in[TI_W'(sp_ff)] = top_lo;
            stk_hi_in[TI_W'(sp_ff)] = mid;
            sp_in = sp_ff + SP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         n_ff  <= '0;
      end else begin
         sp_ff <= sp_in;
         n_ff  <= n_in;
      end
      stk_lo_ff <= stk_lo_in;
      stk_hi_ff <= stk_hi_in;
   end

endmodule
